// ===== rtl/core/tbdlp_pkg.sv =====
// Shared types, codes and reset values for the two-button debounce block.
package tbdlp_pkg;

	// Level packing: bit 0 left, bit 1 right, a zero bit means pressed
	localparam int unsigned LEVELS_W = 2;
	localparam logic [LEVELS_W-1:0] ALL_RELEASED = 2'b11;
	localparam logic [LEVELS_W-1:0] BOTH_PRESSED = 2'b00;

	// Register and counter widths
	localparam int unsigned DEBOUNCE_W = 8;
	localparam int unsigned COUNT_W    = 16;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned EVENT_W    = 3;

	// Register reset values
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 8'd20;
	localparam logic [COUNT_W-1:0]    LONG_PRESS_RST = 16'd1000;
	localparam logic [COUNT_W-1:0]    REPEAT_RST     = 16'd200;

	// Register indexes on the write port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_REPEAT     = 2'd2
	} reg_index_t;

	// Reported events
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE       = 3'd0,
		EV_LEFT_REL   = 3'd1,
		EV_RIGHT_REL  = 3'd2,
		EV_BOTH_REL   = 3'd3,
		EV_LEFT_LONG  = 3'd4,
		EV_RIGHT_LONG = 3'd5,
		EV_BOTH_LONG  = 3'd6
	} event_code_t;

	// Configuration handed from the register file to the core
	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ticks;
		logic [COUNT_W-1:0]    long_press_ticks;
		logic [COUNT_W-1:0]    repeat_ticks;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic        any_held;
		event_code_t event_code;
		logic        press_started;
	} result_t;

endpackage

// ===== rtl/core/tbdlp_cfg.sv =====
// Configuration register file for the two-button debounce block.
module tbdlp_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tbdlp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tbdlp_pkg::CFG_DATA_W-1:0]      cfg_data,
	output tbdlp_pkg::cfg_t                       cfg
);

	tbdlp_pkg::cfg_t cfg_q;

	// Write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= tbdlp_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ticks <= tbdlp_pkg::LONG_PRESS_RST;
			cfg_q.repeat_ticks     <= tbdlp_pkg::REPEAT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tbdlp_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ticks <= cfg_data[tbdlp_pkg::DEBOUNCE_W-1:0];
				end
				tbdlp_pkg::REG_LONG_PRESS: begin
					cfg_q.long_press_ticks <= cfg_data[tbdlp_pkg::COUNT_W-1:0];
				end
				tbdlp_pkg::REG_REPEAT: begin
					cfg_q.repeat_ticks <= cfg_data[tbdlp_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/tbdlp_core.sv =====
// Debounce, press/release and long-press state with its next-state logic.
module tbdlp_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic [tbdlp_pkg::LEVELS_W-1:0]     levels,
	input  tbdlp_pkg::cfg_t                    cfg,
	output tbdlp_pkg::result_t                 res
);

	logic [tbdlp_pkg::LEVELS_W-1:0]   stable_q, stable_d;
	logic [tbdlp_pkg::LEVELS_W-1:0]   cand_q, cand_d;
	logic                             debouncing_q, debouncing_d;
	logic                             both_held_q, both_held_d;
	logic                             single_long_q, single_long_d;
	logic                             both_long_q, both_long_d;
	logic [tbdlp_pkg::DEBOUNCE_W-1:0] deb_cnt_q, deb_cnt_d;
	logic [tbdlp_pkg::COUNT_W-1:0]    hold_cnt_q, hold_cnt_d;
	logic [tbdlp_pkg::COUNT_W-1:0]    rep_cnt_q, rep_cnt_d;
	logic                             press;
	tbdlp_pkg::event_code_t           ev;

	// Work out one tick: next state and the result it causes
	always_comb begin
		stable_d      = stable_q;
		cand_d        = cand_q;
		debouncing_d  = debouncing_q;
		both_held_d   = both_held_q;
		single_long_d = single_long_q;
		both_long_d   = both_long_q;
		deb_cnt_d     = deb_cnt_q;
		hold_cnt_d    = hold_cnt_q;
		rep_cnt_d     = rep_cnt_q;
		press         = 1'b0;
		ev            = tbdlp_pkg::EV_NONE;

		if (debouncing_q) begin
			if (cand_q != levels) begin
				// Level moved during the run: restart it
				deb_cnt_d  = '0;
				hold_cnt_d = '0;
				rep_cnt_d  = '0;
				cand_d     = levels;
			end else if (deb_cnt_q < cfg.debounce_ticks) begin
				deb_cnt_d = deb_cnt_q + 1'b1;
			end else begin
				// Accept the candidate and report the change
				stable_d     = cand_q;
				deb_cnt_d    = '0;
				hold_cnt_d   = '0;
				rep_cnt_d    = '0;
				debouncing_d = 1'b0;
				if (cand_q != stable_q) begin
					if (stable_q == tbdlp_pkg::ALL_RELEASED) begin
						press = 1'b1;
					end
					if (both_held_q) begin
						if (cand_q == tbdlp_pkg::ALL_RELEASED && !both_long_q) begin
							ev = tbdlp_pkg::EV_BOTH_REL;
						end
					end else if (cand_q == tbdlp_pkg::BOTH_PRESSED) begin
						both_held_d = 1'b1;
					end else if (single_long_q) begin
						// Release after a long press stays silent
					end else if (cand_q[0] && !stable_q[0]) begin
						ev = tbdlp_pkg::EV_LEFT_REL;
					end else if (cand_q[1] && !stable_q[1]) begin
						ev = tbdlp_pkg::EV_RIGHT_REL;
					end
					if (cand_q == tbdlp_pkg::ALL_RELEASED) begin
						both_held_d   = 1'b0;
						single_long_d = 1'b0;
						both_long_d   = 1'b0;
					end
				end
			end
		end else begin
			// Advance hold and repeat timing while something is held
			if (stable_q != tbdlp_pkg::ALL_RELEASED) begin
				if (hold_cnt_q < cfg.long_press_ticks) begin
					hold_cnt_d = hold_cnt_q + 1'b1;
				end else if (rep_cnt_q < cfg.repeat_ticks) begin
					rep_cnt_d = rep_cnt_q + 1'b1;
				end else begin
					rep_cnt_d = '0;
					press     = 1'b1;
					if (stable_q == tbdlp_pkg::BOTH_PRESSED) begin
						if (!both_long_q) begin
							both_long_d = 1'b1;
							ev          = tbdlp_pkg::EV_BOTH_LONG;
						end
					end else if (both_held_q) begin
						// One button left over from a both-held press
					end else if (!stable_q[1]) begin
						single_long_d = 1'b1;
						ev            = tbdlp_pkg::EV_RIGHT_LONG;
					end else begin
						single_long_d = 1'b1;
						ev            = tbdlp_pkg::EV_LEFT_LONG;
					end
				end
			end else begin
				hold_cnt_d = '0;
				rep_cnt_d  = '0;
			end
			// Start a debounce run on a new raw level
			if (levels != stable_q) begin
				deb_cnt_d    = '0;
				hold_cnt_d   = '0;
				rep_cnt_d    = '0;
				cand_d       = levels;
				debouncing_d = 1'b1;
			end
		end
	end

	// Hold state until a tick is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= tbdlp_pkg::ALL_RELEASED;
			cand_q        <= tbdlp_pkg::ALL_RELEASED;
			debouncing_q  <= 1'b0;
			both_held_q   <= 1'b0;
			single_long_q <= 1'b0;
			both_long_q   <= 1'b0;
			deb_cnt_q     <= '0;
			hold_cnt_q    <= '0;
			rep_cnt_q     <= '0;
		end else if (advance) begin
			stable_q      <= stable_d;
			cand_q        <= cand_d;
			debouncing_q  <= debouncing_d;
			both_held_q   <= both_held_d;
			single_long_q <= single_long_d;
			both_long_q   <= both_long_d;
			deb_cnt_q     <= deb_cnt_d;
			hold_cnt_q    <= hold_cnt_d;
			rep_cnt_q     <= rep_cnt_d;
		end
	end

	assign res.press_started = press;
	assign res.event_code    = ev;
	assign res.any_held      = (stable_d != tbdlp_pkg::ALL_RELEASED);

endmodule

// ===== rtl/core/two_button_debounce_long_press.sv =====
// Top level: tick input register, debounce core, result register and config port.
// Path: a tick is taken into the input register, worked by the core logic and its result
// captured in the result register; it waits in the input register while the result side stalls.
// Throughput: one tick per cycle while the result side takes results; the state update is one pass of logic.
// Reset (arst_n low): both stages empty, buttons seen as released, registers
// back to debounce 20, long press 1000 and repeat 200 ticks.
module two_button_debounce_long_press (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,  // [0] left_level, [1] right_level
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [7:0]                           m_axis_tdata,  // [0] press_started, [3:1] event_code, [4] any_held
	input  logic                                 cfg_we,
	input  logic [tbdlp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tbdlp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                             valid_s1;
	logic [tbdlp_pkg::LEVELS_W-1:0]   levels_s1;
	logic                             out_valid_q;
	tbdlp_pkg::result_t               out_res_q;
	tbdlp_pkg::result_t               res;
	tbdlp_pkg::cfg_t                  cfg;
	logic                             advance;

	// Process the held tick when the result register is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			levels_s1 <= s_axis_tdata[tbdlp_pkg::LEVELS_W-1:0];
		end
	end

	tbdlp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tbdlp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.levels  (levels_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_res_q.any_held, out_res_q.event_code,
		out_res_q.press_started};

	// A stalled tick in the input register keeps its levels
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(levels_s1)))
		else $error("input register lost a stalled tick");

	// Long-press events always come with press_started
	a_long_press: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_res_q.event_code == tbdlp_pkg::EV_LEFT_LONG ||
		out_res_q.event_code == tbdlp_pkg::EV_RIGHT_LONG ||
		out_res_q.event_code == tbdlp_pkg::EV_BOTH_LONG)) |-> out_res_q.press_started)
		else $error("long press without press_started");

	// A both-release leaves nothing held
	a_both_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_res_q.event_code == tbdlp_pkg::EV_BOTH_REL)
		|-> !out_res_q.any_held)
		else $error("both release reported while a button is held");

endmodule
